// ----- sv/wpsd_pkg.sv -----
// Shared types, constants and helpers for the windowed peak step detector.
// Used by every module of the block but wpsd_ram; depends on nothing else.
package wpsd_pkg;

  localparam int HALF_WINDOW = 12;
  localparam int WIN_DEPTH   = 2 * HALF_WINDOW;
  localparam int ADDR_W      = $clog2(WIN_DEPTH);
  localparam int OFF_W       = $clog2(HALF_WINDOW);
  localparam int CNT_W       = $clog2(HALF_WINDOW + 4);
  localparam int SAMPLE_W    = 20;
  localparam int SUM_W       = SAMPLE_W + 2;
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int LIM_W       = SAMPLE_W + 3;
  localparam int THR_W       = 21;
  localparam int SENS_W      = 16;
  localparam int BATCH_W     = 8;
  localparam int TOTAL_W     = 32;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = BATCH_W + TOTAL_W;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [SENS_W-1:0] SENS_RESET   = 16'd150;
  localparam logic              REG_SENS_IDX = 1'b0;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    SEL_FILT,
    SEL_W2,
    SEL_W1,
    SEL_W0
  } tap_sel_t;

  typedef struct packed {
    logic     shift;
    tap_sel_t sel;
  } filt_ctl_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic trough;
  } emit_t;

  function automatic logic [ADDR_W-1:0] phys_addr(input logic swap, input logic half,
                                                  input logic [OFF_W-1:0] off);
    logic [ADDR_W-1:0] base;
    base = (half ^ swap) ? ADDR_W'(HALF_WINDOW) : '0;
    return base + ADDR_W'(off);
  endfunction

endpackage

// ----- sv/wpsd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; holds the sample window of the step detector.
module wpsd_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/wpsd_filter.sv -----
// Four-tap moving average unit: a three-deep tap line fed from the window RAM
// and one shared adder with truncation toward zero. Depends on wpsd_pkg.
module wpsd_filter
  import wpsd_pkg::*;
(
  input  logic      clk,
  input  filt_ctl_t ctl,
  input  sample_t   rd_data,
  output sample_t   filt,
  output sample_t   emit
);

  sample_t                 w0;
  sample_t                 w1;
  sample_t                 w2;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] adj;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      w0 <= rd_data;
      w1 <= w0;
      w2 <= w1;
    end
  end

  always_comb begin
    sum  = {{2{rd_data[SAMPLE_W-1]}}, rd_data} + {{2{w0[SAMPLE_W-1]}}, w0}
         + {{2{w1[SAMPLE_W-1]}}, w1} + {{2{w2[SAMPLE_W-1]}}, w2};
    adj  = sum + {{(SUM_W-2){1'b0}}, {2{sum[SUM_W-1]}}};
    filt = adj[SUM_W-1:2];
    case (ctl.sel)
      SEL_FILT: emit = filt;
      SEL_W2:   emit = w2;
      SEL_W1:   emit = w1;
      SEL_W0:   emit = w0;
      default:  emit = filt;
    endcase
  end

endmodule

// ----- sv/wpsd_extreme.sv -----
// Peak and trough tracker: one registered compare stage that is shared by the
// peak search of the first half and the trough search of the second half.
// Depends on wpsd_pkg.
module wpsd_extreme
  import wpsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic [THR_W-1:0]  threshold,
  input  logic [SENS_W-1:0] sens,
  input  emit_t             ctl,
  input  sample_t           value,
  output sample_t           peak,
  output sample_t           trough
);

  emit_t                   st;
  sample_t                 st_val;
  logic signed [LIM_W-1:0] hi_lim;
  logic signed [LIM_W-1:0] lo_lim;
  logic signed [LIM_W-1:0] vx;
  sample_t                 pk_best;
  sample_t                 pk_first;
  logic                    pk_any;
  sample_t                 tr_best;
  sample_t                 tr_first;
  logic                    tr_any;

  assign vx = {{(LIM_W-SAMPLE_W){st_val[SAMPLE_W-1]}}, st_val};

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= '0;
      pk_any <= 1'b0;
      tr_any <= 1'b0;
    end else if (clear) begin
      st     <= '0;
      pk_any <= 1'b0;
      tr_any <= 1'b0;
      hi_lim <= $signed({2'b00, threshold}) + $signed({8'b0, sens[SENS_W-1:1]});
      lo_lim <= $signed({2'b00, threshold}) - $signed({8'b0, sens[SENS_W-1:1]});
    end else begin
      st     <= ctl;
      st_val <= value;
      if (st.valid) begin
        if (st.first) begin
          if (st.trough) begin
            tr_first <= st_val;
          end else begin
            pk_first <= st_val;
          end
        end else if (st.trough) begin
          if (vx < lo_lim && (!tr_any || st_val < tr_best)) begin
            tr_best <= st_val;
            tr_any  <= 1'b1;
          end
        end else begin
          if (vx > hi_lim && (!pk_any || st_val > pk_best)) begin
            pk_best <= st_val;
            pk_any  <= 1'b1;
          end
        end
      end
    end
  end

  assign peak   = (pk_any && pk_best > pk_first) ? pk_best : pk_first;
  assign trough = (tr_any && tr_best < tr_first) ? tr_best : tr_first;

endmodule

// ----- sv/windowed_peak_step_detector.sv -----
// Top level of the windowed peak step detector: stream ports, APB register,
// evaluation sequencer and step counters. Depends on wpsd_pkg, wpsd_ram,
// wpsd_filter and wpsd_extreme.
//
// Samples arrive on the s_ channel (tdata = sample, tlast = last of batch);
// one result per sample leaves on the m_ channel. A sample that does not fill
// the window gives its result in the cycle after its transfer. The sample that
// fills the 24-entry window starts an evaluation: each half is walked once
// through the window RAM's read port while the filter adder writes smoothed
// entries back and the shared compare stage tracks the peak or trough. The
// FLUSH, DECIDE and RESULT states then close the evaluation, and s_tready
// stays low from such a sample's transfer until its result.
// While a result waits in the output register and m_tready is low, s_tready
// stays low, so the block holds at most one finished result.
// The window halves swap roles by a pointer bit instead of a copy.
// Reset empties the window, clears the threshold and both step counts, and
// sets sensitivity to 150. Sensitivity is at APB byte address 0.
module windowed_peak_step_detector
  import wpsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // [19:0] sample, rest zero
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // [7:0] batch_steps, [39:8] total_steps
  output logic [1:0]            m_tuser,  // [0] step_found, [1] window_evaluated
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [4:0] {
    IDLE   = 5'b00001,
    EVAL   = 5'b00010,
    FLUSH  = 5'b00100,
    DECIDE = 5'b01000,
    RESULT = 5'b10000
  } state_t;

  state_t                     state;
  logic [CNT_W-1:0]           cnt;
  logic                       half;
  logic                       swap;
  logic [ADDR_W-1:0]          fill;
  logic [THR_W-1:0]           thr;
  logic [SENS_W-1:0]          sens;
  logic [BATCH_W-1:0]         batch;
  logic [TOTAL_W-1:0]         total;
  logic                       last_r;
  logic signed [DIFF_W-1:0]   diff_r;

  logic                       s_acc;
  logic                       trig;
  logic                       out_free;
  logic                       fire;
  logic                       fill_hi;
  logic [OFF_W-1:0]           fill_off;
  logic [OFF_W-1:0]           rd_off;
  logic [CNT_W-1:0]           wr_idx;
  logic                       eval_wr;
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [SAMPLE_W-1:0]        ram_wdata;
  logic [ADDR_W-1:0]          ram_raddr;
  logic [SAMPLE_W-1:0]        ram_rdata;
  filt_ctl_t                  fctl;
  emit_t                      ectl;
  sample_t                    filt;
  sample_t                    emit;
  sample_t                    peak;
  sample_t                    trough;
  logic                       step_c;
  logic                       step_now;
  logic                       eval_now;
  logic                       last_now;
  logic [BATCH_W-1:0]         batch_new;
  logic [TOTAL_W-1:0]         total_new;
  logic                       cfg_wr;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == IDLE) && out_free;
  assign s_acc    = s_tvalid && s_tready;
  assign trig     = (fill == ADDR_W'(WIN_DEPTH - 1));

  assign fill_hi  = (fill >= ADDR_W'(HALF_WINDOW));
  assign fill_off = fill_hi ? OFF_W'(fill - ADDR_W'(HALF_WINDOW)) : fill[OFF_W-1:0];
  assign rd_off   = OFF_W'(HALF_WINDOW - 1) - cnt[OFF_W-1:0];
  assign wr_idx   = CNT_W'(HALF_WINDOW + 3) - cnt;
  assign eval_wr  = (state == EVAL) && (cnt >= CNT_W'(4)) && (cnt <= CNT_W'(HALF_WINDOW));

  always_comb begin
    ram_we    = s_acc || eval_wr;
    ram_raddr = phys_addr(swap, half, rd_off);
    if (s_acc) begin
      ram_waddr = phys_addr(swap, fill_hi, fill_off);
      ram_wdata = s_tdata[SAMPLE_W-1:0];
    end else begin
      ram_waddr = phys_addr(swap, half, wr_idx[OFF_W-1:0]);
      ram_wdata = filt;
    end
  end

  always_comb begin
    fctl.shift = (state == EVAL) && (cnt >= CNT_W'(1)) && (cnt <= CNT_W'(HALF_WINDOW));
    if (cnt == CNT_W'(HALF_WINDOW + 1)) begin
      fctl.sel = SEL_W2;
    end else if (cnt == CNT_W'(HALF_WINDOW + 2)) begin
      fctl.sel = SEL_W1;
    end else if (cnt == CNT_W'(HALF_WINDOW + 3)) begin
      fctl.sel = SEL_W0;
    end else begin
      fctl.sel = SEL_FILT;
    end
    ectl.valid  = eval_wr || ((state == EVAL) && (cnt > CNT_W'(HALF_WINDOW)));
    ectl.first  = (cnt == CNT_W'(HALF_WINDOW + 3));
    ectl.trough = half;
  end

  wpsd_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WIN_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  wpsd_filter u_filter (
    .clk    (clk),
    .ctl    (fctl),
    .rd_data(ram_rdata),
    .filt   (filt),
    .emit   (emit)
  );

  wpsd_extreme u_extreme (
    .clk      (clk),
    .rst      (rst),
    .clear    (s_acc && trig),
    .threshold(thr),
    .sens     (sens),
    .ctl      (ectl),
    .value    (emit),
    .peak     (peak),
    .trough   (trough)
  );

  assign step_c = !diff_r[DIFF_W-1] && ($unsigned(diff_r) > DIFF_W'(sens));

  always_comb begin
    if (state == RESULT) begin
      fire     = out_free;
      step_now = step_c;
      eval_now = 1'b1;
      last_now = last_r;
    end else begin
      fire     = s_acc && !trig;
      step_now = 1'b0;
      eval_now = 1'b0;
      last_now = s_tlast;
    end
    batch_new = (step_now && batch != '1) ? batch + BATCH_W'(1) : batch;
    total_new = (step_now && total != '1) ? total + TOTAL_W'(1) : total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      cnt      <= '0;
      half     <= 1'b0;
      swap     <= 1'b0;
      fill     <= '0;
      thr      <= '0;
      batch    <= '0;
      total    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {total_new, batch_new};
        m_tuser  <= {eval_now, step_now};
        batch    <= last_now ? '0 : batch_new;
        total    <= total_new;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_acc) begin
            if (trig) begin
              state  <= EVAL;
              cnt    <= '0;
              half   <= 1'b0;
              last_r <= s_tlast;
            end else begin
              fill <= fill + ADDR_W'(1);
            end
          end
        end
        EVAL: begin
          if (cnt == CNT_W'(HALF_WINDOW + 3)) begin
            cnt <= '0;
            if (half) begin
              state <= FLUSH;
            end else begin
              half <= 1'b1;
            end
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        FLUSH: begin
          state <= DECIDE;
        end
        DECIDE: begin
          diff_r <= {peak[SAMPLE_W-1], peak} - {trough[SAMPLE_W-1], trough};
          state  <= RESULT;
        end
        RESULT: begin
          if (out_free) begin
            state <= IDLE;
            half  <= 1'b0;
            if (step_c) begin
              thr  <= diff_r[THR_W-1:0];
              fill <= '0;
            end else begin
              swap <= ~swap;
              fill <= ADDR_W'(HALF_WINDOW);
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SENS_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      sens <= SENS_RESET;
    end else if (cfg_wr) begin
      sens <= pwdata[SENS_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_SENS_IDX) ? {{(APB_DATA_W-SENS_W){1'b0}}, sens} : '0;

endmodule

// ----- dv/windowed_peak_step_detector_test.sv -----
// Self-checking testbench for the windowed peak step detector.
// Drives sample transfers and APB writes, predicts each result with its own model of the
// window filter, peak and trough search and step counts. Depends on wpsd_pkg and the RTL.
`timescale 1ns / 1ps

module windowed_peak_step_detector_test
  import wpsd_pkg::*;
();

  typedef struct packed {
    logic               step_found;
    logic               window_evaluated;
    logic [BATCH_W-1:0] batch_steps;
    logic [TOTAL_W-1:0] total_steps;
  } step_report_t;

  typedef enum int {
    BLK_HIGH,
    BLK_LOW,
    BLK_NOISE,
    BLK_FLAT
  } block_kind_t;

  localparam logic [APB_ADDR_W-1:0] SENS_ADDR = APB_ADDR_W'(4 * REG_SENS_IDX);
  localparam int SAMPLE_MAX = 524287;
  localparam int SAMPLE_MIN = -524288;
  localparam int TAPS       = 4;
  localparam longint TOTAL_MAX = 64'hFFFF_FFFF;

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  s_tlast  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Detector state as predicted from the accepted transfers.
  int     window_q [WIN_DEPTH];
  int     fill_level  = 0;
  int     threshold_q = 0;
  int     batch_count = 0;
  longint total_count = 0;
  int     sens_cfg    = int'(SENS_RESET);

  step_report_t step_results_due[$];
  int           mismatches  = 0;
  int           hold_cycles = 0;
  bit           steady_flow = 1'b0;

  windowed_peak_step_detector dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint expected,
                                 input longint actual);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch in %s: expected %0d, got %0d at %0t", what, expected, actual, $realtime);
    end
  endtask

  function automatic step_report_t predict_step_result(input sample_t value, input bit last);
    step_report_t r;
    int     half_sens;
    int     peak;
    int     trough;
    int     acc;
    int     h;
    int     i;
    bit     stepped;
    r = '0;
    stepped = 1'b0;
    if (fill_level >= WIN_DEPTH) begin
      fill_level = 0;
    end
    window_q[fill_level] = int'(value);
    fill_level++;
    if (fill_level >= WIN_DEPTH) begin
      r.window_evaluated = 1'b1;
      for (h = 0; h < 2; h++) begin
        for (i = HALF_WINDOW - 1; i >= TAPS - 1; i--) begin
          acc = window_q[h*HALF_WINDOW + i] + window_q[h*HALF_WINDOW + i - 1] +
                window_q[h*HALF_WINDOW + i - 2] + window_q[h*HALF_WINDOW + i - 3];
          window_q[h*HALF_WINDOW + i] = acc / TAPS;
        end
      end
      half_sens = sens_cfg / 2;
      peak = window_q[0];
      for (i = 1; i < HALF_WINDOW; i++) begin
        if (window_q[i] > peak && window_q[i] > threshold_q + half_sens) begin
          peak = window_q[i];
        end
      end
      trough = window_q[HALF_WINDOW];
      for (i = HALF_WINDOW + 1; i < WIN_DEPTH; i++) begin
        if (window_q[i] < trough && window_q[i] < threshold_q - half_sens) begin
          trough = window_q[i];
        end
      end
      stepped = (peak >= trough) && (peak - trough > sens_cfg);
      if (stepped) begin
        threshold_q = peak - trough;
        fill_level = 0;
        if (batch_count < 255) begin
          batch_count++;
        end
        if (total_count < TOTAL_MAX) begin
          total_count++;
        end
      end else begin
        for (i = 0; i < HALF_WINDOW; i++) begin
          window_q[i] = window_q[i + HALF_WINDOW];
        end
        fill_level = HALF_WINDOW;
      end
    end
    r.step_found  = stepped;
    r.batch_steps = BATCH_W'(batch_count);
    r.total_steps = TOTAL_W'(total_count);
    if (last) begin
      batch_count = 0;
    end
    return r;
  endfunction

  task automatic send_sample(input sample_t value, input bit last);
    @(negedge clk);
    while (!steady_flow && $urandom_range(99) < 11) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - SAMPLE_W){1'b0}}, value};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    step_results_due.push_back(predict_step_result(value, last));
  endtask

  task automatic send_block(input block_kind_t kind, input int amp, input int len);
    int level;
    int jit;
    int v;
    int i;
    jit = amp / 64;
    level = 0;
    case (kind)
      BLK_HIGH: begin
        level = amp / 2 + int'($urandom_range(amp / 2));
      end
      BLK_LOW: begin
        level = -(amp / 2) - int'($urandom_range(amp / 2));
      end
      BLK_FLAT: begin
        level = int'($urandom_range(2 * amp)) - amp;
        jit = 0;
      end
      default: begin
      end
    endcase
    for (i = 0; i < len; i++) begin
      if (kind == BLK_NOISE) begin
        v = int'(sample_t'($urandom));
      end else begin
        v = level + int'($urandom_range(2 * jit)) - jit;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        if (v < SAMPLE_MIN) v = SAMPLE_MIN;
      end
      send_sample(sample_t'(v), $urandom_range(99) < 4);
    end
  endtask

  task automatic wait_drained(input int extra);
    @(negedge clk);
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    while (step_results_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == SENS_ADDR) begin
      sens_cfg = int'(data[SENS_W-1:0]);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_check_sensitivity();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= SENS_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DATA_W'(sens_cfg)) begin
      report_mismatch("sensitivity readback", sens_cfg, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles--;
    end else begin
      m_tready <= steady_flow || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk) begin : check_results
    step_report_t due;
    if (!rst && m_tvalid && m_tready) begin
      if (step_results_due.size() == 0) begin
        report_mismatch("unexpected result transfer", 0, 1);
      end else begin
        due = step_results_due.pop_front();
        if (m_tuser[0] !== due.step_found) begin
          report_mismatch("step_found", due.step_found, m_tuser[0]);
        end
        if (m_tuser[1] !== due.window_evaluated) begin
          report_mismatch("window_evaluated", due.window_evaluated, m_tuser[1]);
        end
        if (m_tdata[BATCH_W-1:0] !== due.batch_steps) begin
          report_mismatch("batch_steps", due.batch_steps, m_tdata[BATCH_W-1:0]);
        end
        if (m_tdata[BATCH_W +: TOTAL_W] !== due.total_steps) begin
          report_mismatch("total_steps", due.total_steps, m_tdata[BATCH_W +: TOTAL_W]);
        end
      end
    end
  end

  task automatic test_reset_value();
    apb_check_sensitivity();
  endtask

  // Full-scale swing: both sample extremes, the largest threshold and a batch end on
  // the window-completing sample.
  task automatic test_extremes();
    int i;
    for (i = 0; i < HALF_WINDOW; i++) begin
      send_sample(sample_t'(SAMPLE_MAX), 1'b0);
    end
    for (i = 0; i < HALF_WINDOW; i++) begin
      send_sample(sample_t'(SAMPLE_MIN), i == HALF_WINDOW - 1);
    end
    wait_drained(4);
  endtask

  task automatic test_random_batches(input int sens_value, input int count);
    int sent;
    int amp;
    int len;
    apb_write(SENS_ADDR, APB_DATA_W'(sens_value));
    apb_check_sensitivity();
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(2))
        0:       amp = 4000;
        1:       amp = 60000;
        default: amp = 520000;
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6: begin
          send_block(BLK_HIGH, amp, HALF_WINDOW);
          send_block(BLK_LOW, amp, HALF_WINDOW);
          sent += WIN_DEPTH;
        end
        7: begin
          len = $urandom_range(1, HALF_WINDOW);
          send_block(BLK_NOISE, amp, len);
          sent += len;
        end
        8: begin
          send_block(BLK_FLAT, amp, WIN_DEPTH);
          sent += WIN_DEPTH;
        end
        default: begin
          send_block(BLK_LOW, amp, HALF_WINDOW);
          send_block(BLK_HIGH, amp, HALF_WINDOW);
          sent += WIN_DEPTH;
        end
      endcase
    end
    wait_drained(4);
  endtask

  // The receiver stalls for a long stretch while samples keep coming, so the
  // block has to hold its input off.
  task automatic test_backpressure();
    hold_cycles = 400;
    repeat (40) send_sample(sample_t'($urandom), 1'b0);
    wait_drained(4);
  endtask

  // A long run with no idling on either side, with a step in nearly every window.
  task automatic test_steady_steps();
    longint goal;
    steady_flow = 1'b1;
    goal = total_count + 10;
    while (total_count < goal) begin
      if (fill_level == HALF_WINDOW && window_q[0] > 0) begin
        send_block(BLK_LOW, 200000, HALF_WINDOW);
      end else begin
        send_block(BLK_HIGH, 200000, HALF_WINDOW);
      end
    end
    send_sample(sample_t'(0), 1'b1);
    wait_drained(4);
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_value();
    test_extremes();
    test_random_batches(0, 140);
    test_random_batches(65535, 140);
    test_random_batches($urandom_range(1, 65534), 140);
    test_backpressure();
    test_random_batches($urandom_range(1, 2000), 140);
    test_random_batches(int'(SENS_RESET), 140);
    test_steady_steps();
    wait_drained(60);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
